FILE: rtl/htfp_pkg.sv
// Shared constants, types and digit decoding for the hex telemetry frame parser.
package htfp_pkg;

    // Received byte codes
    localparam logic [7:0] BYTE_IDLE = 8'hFF;
    localparam logic [7:0] BYTE_LF   = 8'h0A;
    localparam logic [7:0] BYTE_VEL  = 8'h56;
    localparam logic [7:0] BYTE_DIST = 8'h44;

    // Field geometry
    localparam int VEL_DIGITS  = 4;
    localparam int DIST_DIGITS = 8;
    localparam int VEL_BITS    = 4 * VEL_DIGITS;
    localparam int DIST_BITS   = 4 * DIST_DIGITS;
    localparam int VEL_CNT_W   = $clog2(VEL_DIGITS);
    localparam int DIST_CNT_W  = $clog2(DIST_DIGITS);
    localparam int VALUE_W     = 30;
    localparam int TDATA_W     = 32;

    // Field kind codes
    localparam logic KIND_VEL  = 1'b0;
    localparam logic KIND_DIST = 1'b1;

    typedef struct packed {
        logic                      field_kind;
        logic signed [VALUE_W-1:0] scaled_value;
    } t_result;

    // Map an ASCII decimal or uppercase hex digit to its value; anything else gives its low nibble.
    function automatic logic [3:0] nibble_of(input logic [7:0] b);
        logic [7:0] d;
        begin
            d = 8'h00;
            if (b >= 8'h30 && b <= 8'h39) begin
                d = b - 8'h30;
            end else if (b >= 8'h41 && b <= 8'h46) begin
                d = b - 8'h37;
            end else begin
                d = b;
            end
            nibble_of = d[3:0];
        end
    endfunction

endpackage

FILE: rtl/htfp_out_buf.sv
// Two-entry output register with skid stage for parser results.
module htfp_out_buf (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  htfp_pkg::t_result     i_result,
    output logic                  o_valid,
    input  logic                  i_ready,
    output htfp_pkg::t_result     o_result
);

    logic              r_main_valid;
    logic              r_skid_valid;
    htfp_pkg::t_result r_main;
    htfp_pkg::t_result r_skid;
    logic              in_fire;
    logic              out_fire;

    assign o_ready  = !r_skid_valid;
    assign o_valid  = r_main_valid;
    assign o_result = r_main;
    assign in_fire  = i_valid && o_ready;
    assign out_fire = r_main_valid && i_ready;

    // Control: main holds the head, skid catches a transfer during a stall
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_fire) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= in_fire;
            end
        end else if (in_fire) begin
            if (r_main_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_main_valid <= 1'b1;
            end
        end
    end

    // Payload: move skid into main or load the new result
    always_ff @(posedge i_clk) begin
        if (out_fire) begin
            if (r_skid_valid) begin
                r_main <= r_skid;
            end else begin
                r_main <= i_result;
            end
        end else if (in_fire) begin
            if (r_main_valid) begin
                r_skid <= i_result;
            end else begin
                r_main <= i_result;
            end
        end
    end

    a_skid_behind_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_main_valid)
        else $error("skid entry held without a head entry");

    a_drain_keeps_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && i_ready) |=> r_main_valid)
        else $error("head lost while draining skid entry");

endmodule

FILE: rtl/htfp_parse_core.sv
// Input register, parser state and per-byte field decoding.
module htfp_parse_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [7:0]        i_byte,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output htfp_pkg::t_result o_result
);

    localparam int VB = htfp_pkg::VEL_BITS;
    localparam int DB = htfp_pkg::DIST_BITS;
    localparam int VC = htfp_pkg::VEL_CNT_W;
    localparam int DC = htfp_pkg::DIST_CNT_W;
    localparam int VW = htfp_pkg::VALUE_W;

    logic          r_in_valid;
    logic [7:0]    r_in_byte;
    logic          r_armed,    n_armed;
    logic          r_vel_act,  n_vel_act;
    logic          r_dist_act, n_dist_act;
    logic [VC-1:0] r_vel_cnt,  n_vel_cnt;
    logic [DC-1:0] r_dist_cnt, n_dist_cnt;
    logic [VB-1:0] r_vel_sh,   n_vel_sh;
    logic [DB-1:0] r_dist_sh,  n_dist_sh;

    logic          fire;
    logic          res_valid;
    logic          res_kind;
    logic [3:0]    nib;
    logic [VB-1:0] vel_sum;
    logic [DB-1:0] dist_sum;
    logic [VB-3:0] vel_q;
    logic [DB-3:0] dist_q;

    assign nib      = htfp_pkg::nibble_of(r_in_byte);
    assign fire     = r_in_valid && (!res_valid || i_res_ready);
    assign o_ready  = !r_in_valid || fire;

    // Quarter with truncation toward zero: bias negatives by three, then shift
    assign vel_sum  = n_vel_sh + {{(VB-2){1'b0}}, n_vel_sh[VB-1], n_vel_sh[VB-1]};
    assign dist_sum = n_dist_sh + {{(DB-2){1'b0}}, n_dist_sh[DB-1], n_dist_sh[DB-1]};
    assign vel_q    = vel_sum[VB-1:2];
    assign dist_q   = dist_sum[DB-1:2];

    assign o_res_valid = r_in_valid && res_valid;
    assign o_result.field_kind   = res_kind;
    assign o_result.scaled_value = (res_kind == htfp_pkg::KIND_VEL)
        ? VW'($signed(vel_q)) : VW'($signed(dist_q));

    // Decode the held byte against the current parser state
    always_comb begin
        n_armed    = r_armed;
        n_vel_act  = r_vel_act;
        n_dist_act = r_dist_act;
        n_vel_cnt  = r_vel_cnt;
        n_dist_cnt = r_dist_cnt;
        n_vel_sh   = r_vel_sh;
        n_dist_sh  = r_dist_sh;
        res_valid  = 1'b0;
        res_kind   = htfp_pkg::KIND_VEL;
        priority if (r_in_byte == htfp_pkg::BYTE_IDLE) begin
            // idle fill, drop
        end else if (r_in_byte == htfp_pkg::BYTE_LF) begin
            n_armed = 1'b1;
        end else if (r_armed && r_in_byte == htfp_pkg::BYTE_VEL) begin
            n_armed   = 1'b0;
            n_vel_act = 1'b1;
            n_vel_cnt = '0;
            n_vel_sh  = '0;
        end else if (r_armed && r_in_byte == htfp_pkg::BYTE_DIST) begin
            n_armed    = 1'b0;
            n_dist_act = 1'b1;
            n_dist_cnt = '0;
            n_dist_sh  = '0;
        end else if (r_vel_act) begin
            n_vel_sh  = {r_vel_sh[VB-5:0], nib};
            n_vel_cnt = r_vel_cnt + 1'b1;
            if (r_vel_cnt == VC'(htfp_pkg::VEL_DIGITS - 1)) begin
                n_vel_act = 1'b0;
                n_vel_cnt = '0;
                res_valid = 1'b1;
                res_kind  = htfp_pkg::KIND_VEL;
            end
        end else if (r_dist_act) begin
            n_dist_sh  = {r_dist_sh[DB-5:0], nib};
            n_dist_cnt = r_dist_cnt + 1'b1;
            if (r_dist_cnt == DC'(htfp_pkg::DIST_DIGITS - 1)) begin
                n_dist_act = 1'b0;
                n_dist_cnt = '0;
                res_valid  = 1'b1;
                res_kind   = htfp_pkg::KIND_DIST;
            end
        end else begin
            // no open field, drop the digit
        end
    end

    // Input register: load on every transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_byte;
        end
    end

    // Parser state: advance when the held byte is consumed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed    <= 1'b0;
            r_vel_act  <= 1'b0;
            r_dist_act <= 1'b0;
            r_vel_cnt  <= '0;
            r_dist_cnt <= '0;
            r_vel_sh   <= '0;
            r_dist_sh  <= '0;
        end else if (fire) begin
            r_armed    <= n_armed;
            r_vel_act  <= n_vel_act;
            r_dist_act <= n_dist_act;
            r_vel_cnt  <= n_vel_cnt;
            r_dist_cnt <= n_dist_cnt;
            r_vel_sh   <= n_vel_sh;
            r_dist_sh  <= n_dist_sh;
        end
    end

    a_vel_result_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && res_valid && res_kind == htfp_pkg::KIND_VEL) |=> !r_vel_act)
        else $error("velocity field still open after its result");

    a_dist_needs_vel_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && res_kind == htfp_pkg::KIND_DIST) |-> !r_vel_act)
        else $error("distance result while velocity field open");

    a_stall_holds_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !i_res_ready) |=> (r_in_valid && $stable(r_vel_sh)
            && $stable(r_dist_sh) && $stable(r_in_byte)))
        else $error("parser state moved while result stalled");

endmodule

FILE: rtl/hex_telemetry_frame_parser.sv
// Top level of the hex telemetry frame parser: byte stream in, field results out.
//
// Slave channel (s_axis) takes one received byte per transfer in tdata.
// A line feed arms the header; an armed 'V' opens a four-digit velocity
// field, an armed 'D' an eight-digit distance field. Hex digits shift into
// the open field (velocity first when both are open); 0xFF is ignored.
// When a field takes its last digit, the master channel (m_axis) carries
// one result: tuser gives the kind (0 velocity, 1 distance) and tdata the
// signed field value divided by four, truncated toward zero.
// Throughput: one byte per cycle while the output buffer has room; the parser
// state updates between the input register and the output buffer.
// The last digit byte is held in the input register while its result is
// decoded; the result then loads into the output buffer, whose head entry
// drives m_axis tvalid.
// Reset clears the header flag, both fields and all valid flags; no
// clearing pass is needed.
// When the receiver stalls, the skid stage takes one more result; after
// that a byte that completes a field waits in the input register and
// s_axis tready drops until m_axis drains. Other bytes keep flowing.
module hex_telemetry_frame_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] rx_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [29:0] scaled_value, [31:30] zero
    output logic        o_m_axis_tuser    // [0] field_kind
);

    logic              res_valid;
    logic              res_ready;
    htfp_pkg::t_result res;
    htfp_pkg::t_result out_res;

    htfp_parse_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_byte      (i_s_axis_tdata),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_result    (res)
    );

    htfp_out_buf u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (res_valid),
        .o_ready  (res_ready),
        .i_result (res),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_result (out_res)
    );

    // Pack the result onto the stream bus
    assign o_m_axis_tuser = out_res.field_kind;
    assign o_m_axis_tdata = {{(htfp_pkg::TDATA_W - htfp_pkg::VALUE_W){1'b0}},
                             out_res.scaled_value};

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for the hex telemetry frame parser stream block.
`timescale 1ns / 1ps

module testbench;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 600;
    localparam int DRAIN_CYCLES = 10;
    localparam int DIRECTED_N   = 28;
    localparam logic [31:0] NO_RESULT = 32'd0;

    // One directed stimulus row: byte, whether a fixed result is typed in, that result
    typedef struct packed {
        logic [7:0]        rx;
        logic              has_fixed;
        htfp_pkg::t_result res;
    } t_stim_row;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_data;
    logic        m_user;

    // Parser state as the frame parser should hold it
    logic        hdr_armed;
    logic        vel_open;
    logic        dist_open;
    logic [2:0]  vel_cnt;
    logic [3:0]  dist_cnt;
    logic [15:0] vel_sr;
    logic [31:0] dist_sr;

    htfp_pkg::t_result pending_fields[$];
    int          error_count = 0;
    int          cycle_count = 0;
    bit          src_calm = 1'b0;

    // Extremes, both fields open, idle and line feed inside fields, armed stray byte
    t_stim_row directed_rows [0:DIRECTED_N-1] = '{
        {htfp_pkg::BYTE_IDLE, NO_RESULT},
        {"A",                 NO_RESULT},
        {htfp_pkg::BYTE_LF,   NO_RESULT},
        {htfp_pkg::BYTE_VEL,  NO_RESULT},
        {"7",                 NO_RESULT},
        {"F",                 NO_RESULT},
        {"F",                 NO_RESULT},
        {"F",                 1'b1, htfp_pkg::KIND_VEL, 30'sd8191},
        {htfp_pkg::BYTE_LF,   NO_RESULT},
        {htfp_pkg::BYTE_DIST, NO_RESULT},
        {htfp_pkg::BYTE_LF,   NO_RESULT},
        {htfp_pkg::BYTE_VEL,  NO_RESULT},
        {"8",                 NO_RESULT},
        {"0",                 NO_RESULT},
        {htfp_pkg::BYTE_IDLE, NO_RESULT},
        {"0",                 NO_RESULT},
        {"0",                 1'b1, htfp_pkg::KIND_VEL, -30'sd8192},
        {"8",                 NO_RESULT},
        {"0",                 NO_RESULT},
        {"0",                 NO_RESULT},
        {"0",                 NO_RESULT},
        {"0",                 NO_RESULT},
        {"0",                 NO_RESULT},
        {"0",                 NO_RESULT},
        {"0",                 1'b1, htfp_pkg::KIND_DIST, -30'sd536870912},
        {htfp_pkg::BYTE_LF,   NO_RESULT},
        {"g",                 NO_RESULT},
        {htfp_pkg::BYTE_DIST, NO_RESULT}
    };

    hex_telemetry_frame_parser u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),    // [7:0] rx_byte
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),    // [29:0] scaled_value, [31:30] zero
        .o_m_axis_tuser  (m_user)     // [0] field_kind
    );

    initial begin
        forever #4 clk = ~clk;
    end

    // Decode an ASCII decimal or uppercase hex digit; any other byte yields its low nibble
    function automatic logic [3:0] digit_value(input logic [7:0] b);
        logic [7:0] d;
        if (b >= 8'h30 && b <= 8'h39) begin
            d = b - 8'h30;
        end else if (b >= 8'h41 && b <= 8'h46) begin
            d = b - 8'h37;
        end else begin
            d = b;
        end
        return d[3:0];
    endfunction

    // Advance the parser state by one byte; return 1 when a field completes
    function automatic bit parse_byte(input logic [7:0] b, output htfp_pkg::t_result r);
        int val;
        r = '0;
        parse_byte = 1'b0;
        if (b == htfp_pkg::BYTE_IDLE) begin
            parse_byte = 1'b0;
        end else if (b == htfp_pkg::BYTE_LF) begin
            hdr_armed = 1'b1;
        end else if (hdr_armed && b == htfp_pkg::BYTE_VEL) begin
            vel_open  = 1'b1;
            vel_cnt   = '0;
            vel_sr    = '0;
            hdr_armed = 1'b0;
        end else if (hdr_armed && b == htfp_pkg::BYTE_DIST) begin
            dist_open = 1'b1;
            dist_cnt  = '0;
            dist_sr   = '0;
            hdr_armed = 1'b0;
        end else if (vel_open) begin
            vel_sr  = {vel_sr[11:0], digit_value(b)};
            vel_cnt = vel_cnt + 3'd1;
            if (vel_cnt == htfp_pkg::VEL_DIGITS) begin
                val = $signed(vel_sr);
                r.field_kind   = htfp_pkg::KIND_VEL;
                r.scaled_value = 30'(val / 4);
                vel_open = 1'b0;
                vel_cnt  = '0;
                parse_byte = 1'b1;
            end
        end else if (dist_open) begin
            dist_sr  = {dist_sr[27:0], digit_value(b)};
            dist_cnt = dist_cnt + 4'd1;
            if (dist_cnt == htfp_pkg::DIST_DIGITS) begin
                val = $signed(dist_sr);
                r.field_kind   = htfp_pkg::KIND_DIST;
                r.scaled_value = 30'(val / 4);
                dist_open = 1'b0;
                dist_cnt  = '0;
                parse_byte = 1'b1;
            end
        end
    endfunction

    // Offer one byte after a random gap, hold it until the transfer, record the outcome
    task automatic send_byte(input logic [7:0] b, input bit has_fixed,
                             input htfp_pkg::t_result fixed_res);
        int gap;
        bit done;
        htfp_pkg::t_result r;
        if ($urandom_range(0, 39) == 0) src_calm = !src_calm;
        gap = src_calm ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        @(posedge clk);
        while (!s_ready) @(posedge clk);
        done = parse_byte(b, r);
        if (has_fixed) begin
            pending_fields.push_back(fixed_res);
        end else if (done) begin
            pending_fields.push_back(r);
        end
        @(negedge clk);
    endtask

    // Compare each result transfer with the oldest pending field
    always @(posedge clk) begin : check_results
        htfp_pkg::t_result want;
        if (rst_n && m_valid && m_ready) begin
            if (pending_fields.size() == 0) begin
                $display("%0t: result with none pending, kind %0b tdata %h",
                         $time, m_user, m_data);
                error_count++;
            end else begin
                want = pending_fields.pop_front();
                if (m_user !== want.field_kind) begin
                    $display("%0t: field_kind expected %0b actual %0b",
                             $time, want.field_kind, m_user);
                    error_count++;
                end
                if (m_data !== {2'b00, want.scaled_value}) begin
                    $display("%0t: scaled_value expected %0d (tdata %h) actual %0d (tdata %h)",
                             $time, want.scaled_value, {2'b00, want.scaled_value},
                             $signed(m_data[29:0]), m_data);
                    error_count++;
                end
            end
        end
    end

    // Stop a hung run
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Receiver: stall a random number of cycles once a result is offered
    initial begin : result_sink
        int stall;
        bit calm;
        calm = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever begin
            if ($urandom_range(0, 39) == 0) calm = !calm;
            stall = calm ? 0 : $urandom_range(0, 14);
            if (stall > 0) begin
                m_ready <= 1'b0;
                @(posedge clk);
                while (!m_valid) @(posedge clk);
                @(negedge clk);
                repeat (stall - 1) @(negedge clk);
            end
            m_ready <= 1'b1;
            @(posedge clk);
            while (!m_valid) @(posedge clk);
            @(negedge clk);
        end
    end

    // Reset, directed rows, then random frames with noise
    initial begin : stimulus
        int          random_items;
        int          n_digits;
        int          pattern;
        int          sel;
        logic [7:0]  b;
        logic [7:0]  header;
        logic [3:0]  nib;

        hdr_armed = 1'b0;
        vel_open  = 1'b0;
        dist_open = 1'b0;
        vel_cnt   = '0;
        dist_cnt  = '0;
        vel_sr    = '0;
        dist_sr   = '0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIRECTED_N; i++) begin
            send_byte(directed_rows[i].rx, directed_rows[i].has_fixed, directed_rows[i].res);
        end

        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            sel = $urandom_range(0, 19);
            if (sel == 0) begin
                // idle filler, not counted
                send_byte(htfp_pkg::BYTE_IDLE, 1'b0, '0);
            end else if (sel <= 2) begin
                // line noise between frames
                b = 8'($urandom_range(0, 255));
                send_byte(b, 1'b0, '0);
                if (b != htfp_pkg::BYTE_IDLE) random_items++;
            end else begin
                // frame: line feed, optional stray byte, header, digits
                send_byte(htfp_pkg::BYTE_LF, 1'b0, '0);
                random_items++;
                if ($urandom_range(0, 7) == 0) begin
                    b = 8'($urandom_range(0, 255));
                    send_byte(b, 1'b0, '0);
                    if (b != htfp_pkg::BYTE_IDLE) random_items++;
                end
                header = $urandom_range(0, 1) ? htfp_pkg::BYTE_VEL : htfp_pkg::BYTE_DIST;
                send_byte(header, 1'b0, '0);
                random_items++;
                n_digits = (header == htfp_pkg::BYTE_VEL) ? htfp_pkg::VEL_DIGITS
                                                          : htfp_pkg::DIST_DIGITS;
                if ($urandom_range(0, 9) == 0) n_digits = $urandom_range(0, n_digits - 1);
                pattern = $urandom_range(0, 7);
                for (int k = 0; k < n_digits; k++) begin
                    // nested header: restart or open the other field mid-frame
                    if ($urandom_range(0, 29) == 0) begin
                        send_byte(htfp_pkg::BYTE_LF, 1'b0, '0);
                        send_byte($urandom_range(0, 1) ? htfp_pkg::BYTE_VEL
                                                       : htfp_pkg::BYTE_DIST, 1'b0, '0);
                        random_items += 2;
                    end
                    if ($urandom_range(0, 19) == 0) send_byte(htfp_pkg::BYTE_IDLE, 1'b0, '0);
                    case (pattern)
                        0: begin
                            b = (k == 0) ? "7" : "F";
                        end
                        1: begin
                            b = (k == 0) ? "8" : "0";
                        end
                        default: begin
                            sel = $urandom_range(0, 19);
                            nib = 4'($urandom_range(0, 15));
                            if (sel < 15) begin
                                b = (nib < 10) ? 8'h30 + nib : 8'h37 + nib;
                            end else if (sel < 18) begin
                                b = 8'($urandom_range(8'h61, 8'h66));
                            end else begin
                                b = 8'($urandom_range(0, 255));
                            end
                        end
                    endcase
                    send_byte(b, 1'b0, '0);
                    if (b != htfp_pkg::BYTE_IDLE) random_items++;
                end
            end
        end
        s_valid <= 1'b0;

        // Drain outstanding fields, then watch for strays
        while (pending_fields.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
